>>> rtl/core/bist_pkg.sv
// Shared types and constants for the bounded integer set table.
package bist_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned CAP_RST_MAX = 16;
  localparam logic [4:0]  INIT_CAP_RST = 5'd16;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_REMOVE = 3'd1,
    FN_QUERY  = 3'd2,
    FN_ADJUST = 3'd3,
    FN_LIST   = 3'd4,
    FN_CLEAR  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_PRESENT    = 3'd1,
    ST_FULL       = 3'd2,
    ST_REMOVED    = 3'd3,
    ST_ABSENT     = 3'd4,
    ST_MEMBER     = 3'd5,
    ST_NOT_MEMBER = 3'd6,
    ST_DONE       = 3'd7
  } status_e;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] element;
    logic               element_valid;
    logic [4:0]         count;
    logic [4:0]         capacity;
    logic               last;
  } res_t;

  typedef struct packed {
    logic eq;
    logic above_lo;
    logic below_hi;
  } cmp_t;

endpackage

>>> rtl/core/bist_in_if.sv
// Operation channel: valid/ready handshake with the operation word.
interface bist_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] value;
  logic signed [7:0]  delta;

  modport source (output valid, output func, output value, output delta, input ready);
  modport sink   (input valid, input func, input value, input delta, output ready);
endinterface

>>> rtl/core/bist_out_if.sv
// Result channel: valid/ready handshake with the result word.
interface bist_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] element;
  logic               element_valid;
  logic [4:0]         count;
  logic [4:0]         capacity;
  logic               last;

  modport source (output valid, output status, output element, output element_valid,
                  output count, output capacity, output last, input ready);
  modport sink   (input valid, input status, input element, input element_valid,
                  input count, input capacity, input last, output ready);
endinterface

>>> rtl/core/bounded_integer_set_table.sv
// Bounded integer set table: up to DEPTH distinct signed 32-bit values with a
// count and a capacity, one operation per input word. The block takes one
// operation at a time and drops ready until its last result word is taken.
// All work goes through an entry store with one write and one read port, read
// one entry per cycle into one shared compare unit, so the store scan sets the
// timing. Insert, remove and query scan the stored entries; a hit ends the
// scan early. Adjust, clear and the unused codes answer without a scan.
// Listing selects the next smallest entry with a full scan per result word;
// an empty list answers without a scan. The clear value of the capacity comes
// from a 5-bit register written through cfg_we_i/cfg_wdata_i; the user must
// write it only while the block is idle, and the block itself does not
// enforce this. Values above DEPTH load DEPTH.
module bounded_integer_set_table #(
  parameter int unsigned DEPTH = bist_pkg::DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  bist_in_if.sink    in_if,
  bist_out_if.source out_if
);
  import bist_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  logic [4:0]         init_cap_q;
  res_t               res;
  cmp_t               cmp_res;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;
  logic signed [31:0] cmp_a;
  logic signed [31:0] cmp_lo;
  logic signed [31:0] cmp_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cap_q <= INIT_CAP_RST;
    end else if (cfg_we_i) begin
      init_cap_q <= cfg_wdata_i;
    end
  end

  bist_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_cap_i  (init_cap_q),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_func_i   (in_if.func),
    .in_value_i  (in_if.value),
    .in_delta_i  (in_if.delta),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_res_o   (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .cmp_a_o     (cmp_a),
    .cmp_lo_o    (cmp_lo),
    .cmp_hi_o    (cmp_hi),
    .cmp_i       (cmp_res)
  );

  bist_store #(.DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bist_cmp u_cmp (
    .a_i   (cmp_a),
    .lo_i  (cmp_lo),
    .hi_i  (cmp_hi),
    .res_o (cmp_res)
  );

  assign out_if.status        = res.status;
  assign out_if.element       = res.element;
  assign out_if.element_valid = res.element_valid;
  assign out_if.count         = res.count;
  assign out_if.capacity      = res.capacity;
  assign out_if.last          = res.last;

endmodule

>>> rtl/core/bist_store.sv
// Entry store: one write port, one read port with registered read data.
module bist_store #(
  parameter int unsigned DEPTH = bist_pkg::DEPTH_DEF,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IW-1:0]      waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic [IW-1:0]      raddr_i,
  output logic signed [31:0] rdata_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bist_cmp.sv
// Shared compare unit: equality and signed ordering against two references.
module bist_cmp (
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] lo_i,
  input  logic signed [31:0] hi_i,
  output bist_pkg::cmp_t     res_o
);

  assign res_o.eq       = (a_i == lo_i);
  assign res_o.above_lo = (a_i > lo_i);
  assign res_o.below_hi = (a_i < hi_i);

endmodule

>>> rtl/core/bist_ctrl.sv
// Sequencer: scans the store through the shared compare unit for insert, remove, query and list.
module bist_ctrl #(
  parameter int unsigned DEPTH = bist_pkg::DEPTH_DEF,
  localparam int unsigned IW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4:0]         init_cap_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         in_func_i,
  input  logic signed [31:0] in_value_i,
  input  logic signed [7:0]  in_delta_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bist_pkg::res_t     out_res_o,
  output logic               mem_we_o,
  output logic [IW-1:0]      mem_waddr_o,
  output logic signed [31:0] mem_wdata_o,
  output logic [IW-1:0]      mem_raddr_o,
  input  logic signed [31:0] mem_rdata_i,
  output logic signed [31:0] cmp_a_o,
  output logic signed [31:0] cmp_lo_o,
  output logic signed [31:0] cmp_hi_o,
  input  bist_pkg::cmp_t     cmp_i
);
  import bist_pkg::*;

  localparam int unsigned AW = ((CW > 8) ? CW : 8) + 2;
  localparam logic [CW-1:0] CAP_RST =
    CW'((DEPTH < CAP_RST_MAX) ? DEPTH : CAP_RST_MAX);
  localparam logic signed [AW-1:0] DEPTH_S = AW'(DEPTH);
  localparam logic [CW+4:0] DEPTH_X = (CW+5)'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_MOVE, S_LSCAN, S_RESP
  } state_e;

  state_e             state_q, state_d;
  func_e              func_q, func_d;
  logic signed [31:0] val_q, val_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      cap_q, cap_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               chk_q, chk_d;
  logic [IW-1:0]      chk_idx_q, chk_idx_d;
  logic               hit_q, hit_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic signed [31:0] prev_q, prev_d;
  logic               have_prev_q, have_prev_d;
  logic signed [31:0] best_q, best_d;
  logic               found_q, found_d;
  logic [CW-1:0]      emitted_q, emitted_d;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic signed [31:0] elem_q, elem_d;
  logic               elem_vld_q, elem_vld_d;
  logic               last_q, last_d;

  logic               issuing;
  logic [CW-1:0]      cnt_dec;
  logic signed [AW-1:0] adj_sum;
  logic [CW-1:0]      adj_cap;
  logic [CW+4:0]      cfg_ext;
  logic [CW-1:0]      clr_cap;
  logic [CW+4:0]      cnt_ext;
  logic [CW+4:0]      cap_ext;

  assign issuing = (idx_q < count_q);
  assign cnt_dec = count_q - 1'b1;

  // Capacity adjust: add delta, hold at or above count, saturate at depth.
  assign adj_sum = $signed(AW'(cap_q)) + AW'(in_delta_i);
  always_comb begin
    priority if (adj_sum < $signed(AW'(count_q))) begin
      adj_cap = count_q;
    end else if (adj_sum > DEPTH_S) begin
      adj_cap = CW'(DEPTH);
    end else begin
      adj_cap = adj_sum[CW-1:0];
    end
  end

  assign cfg_ext = (CW+5)'(init_cap_i);
  assign clr_cap = (cfg_ext > DEPTH_X) ? CW'(DEPTH) : cfg_ext[CW-1:0];

  assign cmp_a_o  = mem_rdata_i;
  assign cmp_lo_o = (state_q == S_LSCAN) ? prev_q : val_q;
  assign cmp_hi_o = best_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    val_d       = val_q;
    count_d     = count_q;
    cap_d       = cap_q;
    idx_d       = idx_q;
    chk_d       = chk_q;
    chk_idx_d   = chk_idx_q;
    hit_d       = hit_q;
    pos_d       = pos_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    best_d      = best_q;
    found_d     = found_q;
    emitted_d   = emitted_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    elem_d      = elem_q;
    elem_vld_d  = elem_vld_q;
    last_d      = last_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[IW-1:0];
    mem_wdata_o = val_q;
    mem_raddr_o = idx_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d     = func_e'(in_func_i);
          val_d      = in_value_i;
          idx_d      = '0;
          chk_d      = 1'b0;
          hit_d      = 1'b0;
          status_d   = ST_DONE;
          elem_d     = '0;
          elem_vld_d = 1'b0;
          last_d     = 1'b1;
          unique case (func_e'(in_func_i))
            FN_INSERT, FN_REMOVE, FN_QUERY: begin
              state_d = S_SCAN;
            end
            FN_ADJUST: begin
              cap_d       = adj_cap;
              out_valid_d = 1'b1;
              state_d     = S_RESP;
            end
            FN_LIST: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                state_d     = S_RESP;
              end else begin
                emitted_d   = '0;
                have_prev_d = 1'b0;
                found_d     = 1'b0;
                state_d     = S_LSCAN;
              end
            end
            FN_CLEAR: begin
              count_d     = '0;
              cap_d       = clr_cap;
              out_valid_d = 1'b1;
              state_d     = S_RESP;
            end
            default: begin
              out_valid_d = 1'b1;
              state_d     = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read one entry a cycle; compare the word read last cycle.
        chk_d     = issuing;
        chk_idx_d = idx_q[IW-1:0];
        if (issuing) begin
          idx_d = idx_q + 1'b1;
        end
        priority if (chk_q && cmp_i.eq) begin
          hit_d   = 1'b1;
          pos_d   = chk_idx_q;
          chk_d   = 1'b0;
          state_d = S_DECIDE;
        end else if (!issuing && !chk_q) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SCAN;
        end
      end

      S_DECIDE: begin
        out_valid_d = 1'b1;
        state_d     = S_RESP;
        unique case (func_q)
          FN_QUERY: begin
            status_d = hit_q ? ST_MEMBER : ST_NOT_MEMBER;
          end
          FN_INSERT: begin
            priority if (hit_q) begin
              status_d = ST_PRESENT;
            end else if (count_q >= cap_q) begin
              status_d = ST_FULL;
            end else begin
              mem_we_o = 1'b1;
              count_d  = count_q + 1'b1;
              status_d = ST_ADDED;
            end
          end
          FN_REMOVE: begin
            if (hit_q) begin
              // Fetch the last entry to fill the freed slot.
              count_d     = cnt_dec;
              mem_raddr_o = cnt_dec[IW-1:0];
              out_valid_d = 1'b0;
              state_d     = S_MOVE;
            end else begin
              cap_d    = count_q;
              status_d = ST_ABSENT;
            end
          end
          default: begin
            status_d = ST_DONE;
          end
        endcase
      end

      S_MOVE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = mem_rdata_i;
        cap_d       = count_q;
        status_d    = ST_REMOVED;
        out_valid_d = 1'b1;
        state_d     = S_RESP;
      end

      S_LSCAN: begin
        // Find the smallest entry above the one emitted last.
        chk_d     = issuing;
        chk_idx_d = idx_q[IW-1:0];
        if (issuing) begin
          idx_d = idx_q + 1'b1;
        end
        if (chk_q && (!have_prev_q || cmp_i.above_lo) && (!found_q || cmp_i.below_hi)) begin
          best_d  = mem_rdata_i;
          found_d = 1'b1;
        end
        if (!issuing && !chk_q) begin
          status_d    = ST_DONE;
          elem_d      = best_q;
          elem_vld_d  = 1'b1;
          last_d      = (emitted_q == cnt_dec);
          out_valid_d = 1'b1;
          state_d     = S_RESP;
        end
      end

      S_RESP: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (func_q == FN_LIST && !last_q) begin
            prev_d      = best_q;
            have_prev_d = 1'b1;
            emitted_d   = emitted_q + 1'b1;
            idx_d       = '0;
            chk_d       = 1'b0;
            found_d     = 1'b0;
            state_d     = S_LSCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= FN_INSERT;
      val_q       <= '0;
      count_q     <= '0;
      cap_q       <= CAP_RST;
      idx_q       <= '0;
      chk_q       <= 1'b0;
      chk_idx_q   <= '0;
      hit_q       <= 1'b0;
      pos_q       <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      best_q      <= '0;
      found_q     <= 1'b0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
      elem_q      <= '0;
      elem_vld_q  <= 1'b0;
      last_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      val_q       <= val_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      chk_idx_q   <= chk_idx_d;
      hit_q       <= hit_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      best_q      <= best_d;
      found_q     <= found_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      elem_q      <= elem_d;
      elem_vld_q  <= elem_vld_d;
      last_q      <= last_d;
    end
  end

  assign cnt_ext = (CW+5)'(count_q);
  assign cap_ext = (CW+5)'(cap_q);

  assign out_valid_o             = out_valid_q;
  assign out_res_o.status        = status_q;
  assign out_res_o.element       = elem_q;
  assign out_res_o.element_valid = elem_vld_q;
  assign out_res_o.count         = cnt_ext[4:0];
  assign out_res_o.capacity      = cap_ext[4:0];
  assign out_res_o.last          = last_q;

endmodule

>>> rtl/core/bist_checker.sv
// Port-level checks for the set table, bound to the top level.
module bist_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] out_element_i,
  input logic               out_element_valid_i,
  input logic               out_last_i
);

  // One operation at a time: no new word while a result waits.
  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a result word is pending");

  // Drop ready right after taking an operation word.
  a_accept_drops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input still ready after an accepted word");

  // Only listed elements carry a nonzero element field.
  a_element_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_element_valid_i) |-> (out_element_i == 32'sd0))
    else $error("element nonzero without element_valid");

  // A result without an element is the single result of its operation.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_element_valid_i) |-> out_last_i)
    else $error("single-result word without last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_element_i)))
    else $error("stalled result word changed");

endmodule

bind bounded_integer_set_table bist_checker u_bist_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_if.valid),
  .in_ready_i          (in_if.ready),
  .out_valid_i         (out_if.valid),
  .out_ready_i         (out_if.ready),
  .out_element_i       (out_if.element),
  .out_element_valid_i (out_if.element_valid),
  .out_last_i          (out_if.last)
);

>>> sim/bounded_integer_set_table_tb.sv
// Self-checking testbench for the bounded integer set table with its own set predictor.
module bounded_integer_set_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bist_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam logic [2:0]  FN_SPARE6   = 3'd6;
  localparam logic [2:0]  FN_SPARE7   = 3'd7;
  localparam int          CYCLE_LIMIT = 800000;
  localparam int          TAIL_CYCLES = 320;
  localparam int          SETTLE      = 4;
  localparam int          MAX_SHOWN   = 40;
  localparam int          RAND_PHASES = 6;
  localparam int          PHASE_OPS   = 24;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [4:0] cfg_wdata_i;

  bist_in_if  in_if ();
  bist_out_if out_if ();

  bounded_integer_set_table #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // predicted set state
  logic [31:0] set_entries [DEPTH];
  logic [4:0]  set_count;
  logic [4:0]  set_capacity;
  logic [4:0]  clear_capacity;

  res_t        pending_words [$];
  logic [31:0] value_pool [24];

  int cycles;
  int mismatch_count;
  int words_checked;
  int ops_sent;
  int lists_sent;
  int reg_writes;
  int burst_left;
  int rx_span;
  int rx_tick;
  rx_mode_e rx_mode;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_words.size());
      $display("** bounded_integer_set_table: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  function automatic res_t make_word(status_e st, logic [31:0] elem, logic ev, logic lst);
    res_t w;
    w.status        = st;
    w.element       = elem;
    w.element_valid = ev;
    w.count         = set_count;
    w.capacity      = set_capacity;
    w.last          = lst;
    return w;
  endfunction

  // Apply one accepted operation to the predicted set and queue its result words.
  task automatic predict_op(input logic [2:0] f, input logic [31:0] v,
                            input logic signed [7:0] d);
    int          slot;
    int          cap_next;
    int          j;
    logic [31:0] ordered [DEPTH];
    logic [31:0] key;
    status_e     st;
    st   = ST_DONE;
    slot = -1;
    for (int i = 0; i < set_count; i++)
      if (slot < 0 && set_entries[i] == v) slot = i;
    case (f)
      FN_INSERT: begin
        if (slot >= 0) begin
          st = ST_PRESENT;
        end else if (set_count >= set_capacity || set_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          set_entries[set_count] = v;
          set_count++;
          st = ST_ADDED;
        end
      end
      FN_REMOVE: begin
        if (slot >= 0) begin
          set_count--;
          set_entries[slot] = set_entries[set_count];
          st = ST_REMOVED;
        end else begin
          st = ST_ABSENT;
        end
        set_capacity = set_count;
      end
      FN_QUERY: st = (slot >= 0) ? ST_MEMBER : ST_NOT_MEMBER;
      FN_ADJUST: begin
        cap_next = int'(set_capacity) + int'(d);
        if (cap_next < int'(set_count)) cap_next = int'(set_count);
        if (cap_next > int'(DEPTH)) cap_next = int'(DEPTH);
        set_capacity = cap_next[4:0];
      end
      FN_LIST: begin
        // insertion sort on signed keys, then one word per element
        for (int i = 0; i < set_count; i++) begin
          key = set_entries[i];
          j = i;
          while (j > 0 && $signed(ordered[j - 1]) > $signed(key)) begin
            ordered[j] = ordered[j - 1];
            j--;
          end
          ordered[j] = key;
        end
        for (int i = 0; i < set_count; i++)
          pending_words.push_back(make_word(ST_DONE, ordered[i], 1'b1, i + 1 == set_count));
      end
      FN_CLEAR: begin
        set_count    = '0;
        set_capacity = (clear_capacity > DEPTH) ? DEPTH[4:0] : clear_capacity;
      end
      default: ;
    endcase
    if (f != FN_LIST || set_count == 0)
      pending_words.push_back(make_word(st, '0, 1'b0, 1'b1));
  endtask

  // Send one operation word: when the burst is used up, open a new one after a random gap, then hold until taken.
  task automatic send_op(input logic [2:0] f, input logic [31:0] v = '0,
                         input logic signed [7:0] d = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.value <= v;
    in_if.delta <= d;
    do @(posedge clk_i); while (!in_if.ready);
    predict_op(f, v, d);
    ops_sent++;
    if (f == FN_LIST) lists_sent++;
  endtask

  // Drop valid and hold until every predicted word has been taken.
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_clear_capacity(input logic [4:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    clear_capacity = v;
    reg_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // Result side: stall on a pattern that changes mode every so often.
  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 120);
    end else begin
      rx_span--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  out_if.ready <= 1'b1;
      RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_if.ready <= ($urandom_range(0, 3) == 0);
      default:  out_if.ready <= (rx_tick % 3 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected result word", {29'd0, out_if.status}, '0);
      end else begin
        want = pending_words.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", {29'd0, out_if.status}, {29'd0, want.status});
        if (out_if.element !== want.element)
          report_mismatch("element", out_if.element, want.element);
        if (out_if.element_valid !== want.element_valid)
          report_mismatch("element_valid", {31'd0, out_if.element_valid},
                          {31'd0, want.element_valid});
        if (out_if.count !== want.count)
          report_mismatch("count", {27'd0, out_if.count}, {27'd0, want.count});
        if (out_if.capacity !== want.capacity)
          report_mismatch("capacity", {27'd0, out_if.capacity}, {27'd0, want.capacity});
        if (out_if.last !== want.last)
          report_mismatch("last", {31'd0, out_if.last}, {31'd0, want.last});
      end
    end
  end

  task automatic test_empty_set();
    send_op(FN_QUERY, 32'd0);
    send_op(FN_LIST);
    send_op(FN_ADJUST, '0, 8'sd0);
  endtask

  task automatic test_insert_extremes();
    send_op(FN_INSERT, 32'h8000_0000);
    send_op(FN_INSERT, 32'h7fff_ffff);
    send_op(FN_INSERT, 32'h0000_0000);
    send_op(FN_INSERT, 32'hffff_ffff);
    send_op(FN_INSERT, 32'h7fff_ffff);
    send_op(FN_QUERY, 32'h8000_0000);
    send_op(FN_QUERY, 32'h0000_0001);
    send_op(FN_LIST);
  endtask

  task automatic test_capacity_adjust();
    // pull capacity down to the count, then the next insert is refused
    send_op(FN_ADJUST, '0, -8'sd64);
    send_op(FN_INSERT, 32'd5);
    send_op(FN_ADJUST, '0, 8'sd64);
  endtask

  task automatic test_remove();
    send_op(FN_REMOVE, 32'd0);
    send_op(FN_REMOVE, 32'd12345);
    send_op(FN_LIST);
    send_op(FN_ADJUST, '0, 8'sd3);
  endtask

  task automatic test_spare_codes();
    send_op(FN_SPARE6, 32'h5a5a_5a5a, 8'sd7);
    send_op(FN_SPARE7, 32'ha5a5_a5a5, -8'sd7);
  endtask

  task automatic test_clear_register();
    drain();
    write_clear_capacity(5'd0);
    send_op(FN_CLEAR);
    send_op(FN_INSERT, 32'd9);
    drain();
    // above the store depth: clear loads the depth
    write_clear_capacity(5'd31);
    send_op(FN_CLEAR);
    send_op(FN_INSERT, 32'd9);
    drain();
    write_clear_capacity(5'd16);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 8) return value_pool[$urandom_range(0, 23)];
    return $urandom();
  endfunction

  task automatic test_random_traffic();
    int          roll;
    logic [4:0]  reg_value;
    logic signed [7:0] d;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      case (phase)
        0:       reg_value = 5'd16;
        1:       reg_value = 5'd3;
        2:       reg_value = 5'd31;
        default: reg_value = 5'($urandom_range(0, 31));
      endcase
      write_clear_capacity(reg_value);
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 12; i++) value_pool[i] = $urandom_range(0, 20) - 10;
      for (int i = 12; i < 24; i++) value_pool[i] = $urandom();
      send_op(FN_CLEAR);
      for (int n = 0; n < PHASE_OPS; n++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0) d = 8'($urandom_range(0, 128) - 64);
        else d = 8'($urandom_range(0, 8) - 2);
        if (roll < 38)      send_op(FN_INSERT, pick_value(), d);
        else if (roll < 52) send_op(FN_REMOVE, pick_value(), d);
        else if (roll < 67) send_op(FN_QUERY, pick_value(), d);
        else if (roll < 80) send_op(FN_ADJUST, pick_value(), d);
        else if (roll < 88) send_op(FN_LIST, pick_value(), d);
        else if (roll < 92) send_op(FN_CLEAR, pick_value(), d);
        else if (roll < 94) send_op(roll[0] ? FN_SPARE7 : FN_SPARE6, pick_value(), d);
        else                send_op(FN_INSERT, pick_value(), d);
      end
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.func     = FN_QUERY;
    in_if.value    = '0;
    in_if.delta    = '0;
    out_if.ready   = 1'b0;
    set_count      = '0;
    set_capacity   = (CAP_RST_MAX > DEPTH) ? DEPTH[4:0] : CAP_RST_MAX[4:0];
    clear_capacity = INIT_CAP_RST;
    cycles         = 0;
    mismatch_count = 0;
    words_checked  = 0;
    ops_sent       = 0;
    lists_sent     = 0;
    reg_writes     = 0;
    burst_left     = 0;
    rx_span        = 0;
    rx_tick        = 0;
    rx_mode        = RX_OPEN;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_set();
    test_insert_extremes();
    test_capacity_adjust();
    test_remove();
    test_spare_codes();
    test_clear_register();
    test_random_traffic();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_words.size() != 0)
      report_mismatch("words never delivered", pending_words.size(), '0);

    $display("covered %0d operations (%0d sorted listings), %0d register writes,",
             ops_sent, lists_sent, reg_writes);
    $display("%0d result words checked, %0d mismatches", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** bounded_integer_set_table: PASSED **");
    end else begin
      $display("** bounded_integer_set_table: FAILED **");
    end
    $finish;
  end

endmodule
